### rtl/ssid_pkg.sv
// shared constants, op codes and the cell control word for the sorted set
// no dependencies
package ssid_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // input operation codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // cell operation codes
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  // control word broadcast to every cell
  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

endpackage

### rtl/sorted_set_insert_delete.sv
// sorted set top: one operation applied in the accept cycle, then the set streamed out.
// the first result word is offered in the cycle after the input word is accepted.
// a new input word is taken only after the last word of the set is taken; the emit
// rotation of the cell ring delivers one word per cycle while out_stall is low.
// reset: synchronous active-low rst_n empties the set; cell values need no reset.
// depends on ssid_pkg, ssid_cell, ssid_ctrl
module sorted_set_insert_delete (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [ssid_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ssid_pkg::DATA_W-1:0]  out_element,
  output logic                                out_set_empty,
  output logic                                out_dropped_full,
  output logic                                out_last
);

  ssid_pkg::cell_ctl_t               ctl;
  logic [ssid_pkg::DATA_W-1:0]       val [ssid_pkg::CAPACITY];
  logic [ssid_pkg::CAPACITY-1:0]     lt;
  logic [ssid_pkg::CAPACITY-1:0]     eq;
  logic                              present;

  assign present = |eq;

  // row of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < ssid_pkg::CAPACITY; i++) begin : g_cell
    logic [ssid_pkg::DATA_W-1:0] prev_v;
    logic                        prev_l;
    logic [ssid_pkg::DATA_W-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = ctl.value;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_v = val[i-1];
      assign prev_l = lt[i-1];
    end

    if (i == ssid_pkg::CAPACITY - 1) begin : g_end
      assign next_v = val[i];
    end else begin : g_inner
      assign next_v = val[i+1];
    end

    ssid_cell u_cell (
      .clk      (clk),
      .cell_idx (ssid_pkg::IDX_W'(i)),
      .ctl      (ctl),
      .prev_val (prev_v),
      .prev_lt  (prev_l),
      .next_val (next_v),
      .head_val (val[0]),
      .val      (val[i]),
      .lt       (lt[i]),
      .eq       (eq[i])
    );
  end

  ssid_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .present      (present),
    .ctl          (ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .set_empty    (out_set_empty),
    .dropped_full (out_dropped_full),
    .last         (out_last)
  );

  // output word comes straight from the head cell, or zero when the set is empty
  assign out_element = out_set_empty ? '0 : $signed(val[0]);

endmodule

### rtl/ssid_cell.sv
// one cell of the sorted row: holds one value and trades it with its neighbors
// depends on ssid_pkg
module ssid_cell (
  input  logic                          clk,
  input  logic [ssid_pkg::IDX_W-1:0]    cell_idx,
  input  ssid_pkg::cell_ctl_t           ctl,
  input  logic [ssid_pkg::DATA_W-1:0]   prev_val,
  input  logic                          prev_lt,
  input  logic [ssid_pkg::DATA_W-1:0]   next_val,
  input  logic [ssid_pkg::DATA_W-1:0]   head_val,
  output logic [ssid_pkg::DATA_W-1:0]   val,
  output logic                          lt,
  output logic                          eq
);

  logic [ssid_pkg::DATA_W-1:0] val_r;
  logic [ssid_pkg::DATA_W-1:0] val_nxt;
  logic [ssid_pkg::CNT_W-1:0]  idx_ext;
  logic                        occ;
  logic                        is_tail;

  assign idx_ext = ssid_pkg::CNT_W'(cell_idx);
  assign occ     = idx_ext < ctl.count;
  assign is_tail = idx_ext == (ctl.count - ssid_pkg::CNT_W'(1));

  // compare held value against the broadcast word
  assign lt  = occ && ($signed(val_r) < $signed(ctl.value));
  assign eq  = occ && (val_r == ctl.value);
  assign val = val_r;

  // next value: shift up on insert, down on delete, ring rotate on emit
  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      ssid_pkg::OP_INSERT: begin
        if (!lt) val_nxt = prev_lt ? ctl.value : prev_val;
      end
      ssid_pkg::OP_DELETE: begin
        if (!lt) val_nxt = next_val;
      end
      ssid_pkg::OP_ROTATE: begin
        val_nxt = is_tail ? head_val : next_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### rtl/ssid_ctrl.sv
// sequencer: applies one operation to the cell row, then streams the set out
// depends on ssid_pkg
module ssid_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [ssid_pkg::DATA_W-1:0]   in_value,
  input  logic                          present,
  output ssid_pkg::cell_ctl_t           ctl,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          set_empty,
  output logic                          dropped_full,
  output logic                          last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                       state_r, state_nxt;
  logic [ssid_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [ssid_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       dropped_r, dropped_nxt;
  logic                       in_acc, out_acc, full;
  logic                       do_ins, do_del;
  logic [1:0]                 op;

  assign in_stall = state_r != ST_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = state_r == ST_EMIT;
  assign out_acc  = out_valid && !out_stall;
  assign full     = count_r == ssid_pkg::CNT_W'(ssid_pkg::CAPACITY);

  assign do_ins = in_acc && (in_kind == ssid_pkg::KIND_INSERT) && !present && !full;
  assign do_del = in_acc && (in_kind == ssid_pkg::KIND_DELETE) && present;

  // status of the current word
  assign set_empty    = count_r == '0;
  assign dropped_full = dropped_r;
  assign last = set_empty ||
                (ssid_pkg::CNT_W'(idx_r) == (count_r - ssid_pkg::CNT_W'(1)));

  // cell operation for this cycle
  always_comb begin
    op = ssid_pkg::OP_HOLD;
    if (do_ins)                     op = ssid_pkg::OP_INSERT;
    else if (do_del)                op = ssid_pkg::OP_DELETE;
    else if (out_acc && !set_empty) op = ssid_pkg::OP_ROTATE;
  end

  assign ctl.op    = op;
  assign ctl.value = in_value;
  assign ctl.count = count_r;

  // sequencing
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt   = ST_EMIT;
          idx_nxt     = '0;
          dropped_nxt = (in_kind == ssid_pkg::KIND_INSERT) && !present && full;
          if (do_ins) count_nxt = count_r + ssid_pkg::CNT_W'(1);
          if (do_del) count_nxt = count_r - ssid_pkg::CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last) state_nxt = ST_IDLE;
          else      idx_nxt   = idx_r + ssid_pkg::IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      dropped_r <= dropped_nxt;
    end
  end

`ifndef SYNTH
  // fill never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ssid_pkg::CNT_W'(ssid_pkg::CAPACITY))
    else $error("entry count above capacity");

  // fill is frozen while the set streams out
  a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && $past(state_r == ST_EMIT) |-> $stable(count_r))
    else $error("entry count moved during emit");

  // read index stays inside the set
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && !set_empty |-> ssid_pkg::CNT_W'(idx_r) < count_r)
    else $error("emit index past the set");

  // a taken last word returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && last |=> state_r == ST_IDLE)
    else $error("no return to idle after last word");

  // dropped flag only on a full store
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped_r |-> count_r == ssid_pkg::CNT_W'(ssid_pkg::CAPACITY))
    else $error("dropped flag without full store");
`endif

endmodule
